// ===== design/ue2u_pkg.sv =====
// shared types and constants for the unicode escape to utf-8 converter
// no dependencies
package ue2u_pkg;

  localparam int ESCAPE_DIGITS_DEF = 4;
  localparam int CNT_W             = 3;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_BSLASH = 2'd1,
    MODE_DIGITS = 2'd2
  } parse_mode_t;

  // control half of one queued run of output bytes
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             last;
  } run_ctl_t;

endpackage

// ===== design/ue2u_front.sv =====
// front end: accepts message bytes, tracks escapes, builds runs of output bytes
// depends on ue2u_pkg
module ue2u_front #(
  parameter int EscDigits = ue2u_pkg::ESCAPE_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_byte,
  input  logic                        in_message_last,
  input  logic                        full_i,
  output logic                        push_o,
  output ue2u_pkg::run_ctl_t          run_ctl_o,
  output logic [(EscDigits+2)*8-1:0]  run_data_o
);
  import ue2u_pkg::*;

  localparam int RunN = EscDigits + 2;

  parse_mode_t      mode_r, mode_nxt;
  logic [CNT_W-1:0] dc_r;
  logic [15:0]      cv_r;
  logic             hex_r;
  logic [7:0]       raw_r [EscDigits];

  logic             accept;
  logic             is_hex;
  logic [3:0]       hex_d;
  logic [15:0]      cv_step;
  logic             hex_step;
  logic [CNT_W-1:0] dc_step;
  logic             done;
  logic [7:0]       rb [RunN];
  logic [CNT_W-1:0] cnt;

  assign accept   = in_valid & ~full_i;
  assign in_stall = full_i;

  // hex digit decode, either case
  always_comb begin
    is_hex = 1'b1;
    hex_d  = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_d = in_byte[3:0];
    end else if ((in_byte >= 8'h41 && in_byte <= 8'h46) ||
                 (in_byte >= 8'h61 && in_byte <= 8'h66)) begin
      hex_d = in_byte[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  assign cv_step  = is_hex ? {cv_r[11:0], hex_d} : cv_r;
  assign hex_step = hex_r & is_hex;
  assign dc_step  = dc_r + CNT_W'(1);
  assign done     = (dc_step >= CNT_W'(EscDigits)) || in_message_last;

  // next state
  always_comb begin
    case (mode_r)
      MODE_BSLASH: mode_nxt = (in_byte == CH_U && !in_message_last) ? MODE_DIGITS : MODE_IDLE;
      MODE_DIGITS: mode_nxt = done ? MODE_IDLE : MODE_DIGITS;
      default:     mode_nxt = (in_byte == CH_BSLASH && !in_message_last) ? MODE_BSLASH
                                                                         : MODE_IDLE;
    endcase
  end

  // run of bytes caused by this request
  always_comb begin
    for (int i = 0; i < RunN; i++) rb[i] = 8'h00;
    cnt = '0;
    case (mode_r)
      MODE_BSLASH: begin
        if (!(in_byte == CH_U && !in_message_last)) begin
          rb[0] = CH_BSLASH;
          rb[1] = in_byte;
          cnt   = CNT_W'(2);
        end
      end
      MODE_DIGITS: begin
        if (done) begin
          if (hex_step) begin
            if (cv_step < 16'h0080) begin
              rb[0] = {1'b0, cv_step[6:0]};
              cnt   = (cv_step != 16'h0000) ? CNT_W'(1) : '0;
            end else if (cv_step < 16'h0800) begin
              rb[0] = {3'b110, cv_step[10:6]};
              rb[1] = {2'b10, cv_step[5:0]};
              cnt   = CNT_W'(2);
            end else begin
              rb[0] = {4'b1110, cv_step[15:12]};
              rb[1] = {2'b10, cv_step[11:6]};
              rb[2] = {2'b10, cv_step[5:0]};
              cnt   = CNT_W'(3);
            end
          end else begin
            rb[0] = CH_BSLASH;
            rb[1] = CH_U;
            for (int i = 0; i < EscDigits; i++) begin
              rb[i+2] = (dc_r == CNT_W'(i)) ? in_byte : raw_r[i];
            end
            cnt = dc_step + CNT_W'(2);
          end
        end
      end
      default: begin
        if (!(in_byte == CH_BSLASH && !in_message_last)) begin
          rb[0] = in_byte;
          cnt   = CNT_W'(1);
        end
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < RunN; i++) run_data_o[i*8 +: 8] = rb[i];
  end

  assign run_ctl_o.count = cnt;
  assign run_ctl_o.last  = in_message_last;
  assign push_o          = accept & ((cnt != '0) | in_message_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      dc_r   <= '0;
      cv_r   <= '0;
      hex_r  <= 1'b1;
    end else if (accept) begin
      mode_r <= mode_nxt;
      if (mode_r == MODE_DIGITS && !done) begin
        dc_r  <= dc_step;
        cv_r  <= cv_step;
        hex_r <= hex_step;
      end else begin
        dc_r  <= '0;
        cv_r  <= '0;
        hex_r <= 1'b1;
      end
    end
  end

  // escape bytes kept for raw replay
  always_ff @(posedge clk) begin
    if (accept && mode_r == MODE_DIGITS) begin
      for (int i = 0; i < EscDigits; i++) begin
        if (dc_r == CNT_W'(i)) raw_r[i] <= in_byte;
      end
    end
  end

endmodule

// ===== design/ue2u_queue.sv =====
// two-entry queue of runs between front and back end
// depends on nothing but its width parameter
module ue2u_queue #(
  parameter int Width = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [Width-1:0] slot0_r, slot1_r;
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       fill_r;
  logic             do_push, do_pop;

  assign full_o  = fill_r == 2'd2;
  assign empty_o = fill_r == 2'd0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = rd_ptr_r ? slot1_r : slot0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      if (do_push && !do_pop)      fill_r <= fill_r + 2'd1;
      else if (do_pop && !do_push) fill_r <= fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push && !wr_ptr_r) slot0_r <= wdata_i;
    if (do_push &&  wr_ptr_r) slot1_r <= wdata_i;
  end

endmodule

// ===== design/ue2u_back.sv =====
// back end: plays one queued run out as result bytes, one per cycle while the result side does not stall
// depends on ue2u_pkg
module ue2u_back #(
  parameter int EscDigits = ue2u_pkg::ESCAPE_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty_i,
  input  ue2u_pkg::run_ctl_t          q_ctl_i,
  input  logic [(EscDigits+2)*8-1:0]  q_data_i,
  output logic                        pop_o,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic                        out_byte_valid,
  output logic                        out_message_end,
  output logic                        out_run_last
);
  import ue2u_pkg::*;

  localparam int RunN = EscDigits + 2;

  logic                  busy_r;
  logic [CNT_W-1:0]      pos_r;
  run_ctl_t              cur_ctl_r;
  logic [RunN*8-1:0]     cur_data_r;

  logic [CNT_W-1:0]      last_pos;
  logic                  is_end;
  logic                  take;
  logic                  load;
  logic [7:0]            sel_byte;

  assign last_pos = (cur_ctl_r.count == '0) ? '0 : cur_ctl_r.count - CNT_W'(1);
  assign is_end   = pos_r == last_pos;
  assign take     = busy_r & ~out_stall;
  assign load     = ~q_empty_i & (~busy_r | (take & is_end));
  assign pop_o    = load;

  always_comb begin
    sel_byte = 8'h00;
    for (int i = 0; i < RunN; i++) begin
      if (pos_r == CNT_W'(i)) sel_byte = cur_data_r[i*8 +: 8];
    end
  end

  assign out_valid       = busy_r;
  assign out_byte_valid  = cur_ctl_r.count != '0;
  assign out_byte        = out_byte_valid ? sel_byte : 8'h00;
  assign out_run_last    = is_end;
  assign out_message_end = is_end & cur_ctl_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      pos_r  <= '0;
    end else if (take && is_end) begin
      busy_r <= 1'b0;
    end else if (take) begin
      pos_r <= pos_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_ctl_r  <= q_ctl_i;
      cur_data_r <= q_data_i;
    end
  end

endmodule

// ===== design/unicode_escape_to_utf8.sv =====
// Converts a byte stream with JSON-style \uXXXX escapes into UTF-8. One
// message byte is taken per cycle whenever the run queue has room; each byte
// yields zero to EscDigits+2 result bytes, delivered one per cycle while
// the result side does not stall. Ordinary bytes and backslash pairs pass
// through, a complete hex escape becomes 1 to 3 UTF-8 bytes (U+0000 gives
// none), and a broken escape is replayed raw. A message-ending byte that
// yields nothing gives one bare end item. The input side takes a request
// every cycle until the two-run queue fills, when runs outpace the result
// side. Each run is registered in a queue slot, then in the back end's
// run register, before its first result byte leaves.
// depends on ue2u_pkg, ue2u_front, ue2u_queue, ue2u_back
module unicode_escape_to_utf8 #(
  parameter int EscDigits = ue2u_pkg::ESCAPE_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel: one message byte per request
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_message_last,
  // result channel: at most one output byte per request
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_message_end,
  output logic       out_run_last
);
  import ue2u_pkg::*;

  localparam int RunW = (EscDigits + 2) * 8;
  localparam int QW   = $bits(run_ctl_t) + RunW;

  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;
  run_ctl_t        f_ctl;
  logic [RunW-1:0] f_data;
  run_ctl_t        q_ctl;
  logic [RunW-1:0] q_data;
  logic [QW-1:0]   q_rdata;

  // front: escape parsing and run building
  ue2u_front #(.EscDigits(EscDigits)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_message_last (in_message_last),
    .full_i          (q_full),
    .push_o          (push),
    .run_ctl_o       (f_ctl),
    .run_data_o      (f_data)
  );

  // queue decouples the two sides
  ue2u_queue #(.Width(QW)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .wdata_i ({f_ctl, f_data}),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign q_ctl  = q_rdata[QW-1:RunW];
  assign q_data = q_rdata[RunW-1:0];

  // back: serializes runs onto the result channel
  ue2u_back #(.EscDigits(EscDigits)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty_i       (q_empty),
    .q_ctl_i         (q_ctl),
    .q_data_i        (q_data),
    .pop_o           (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_message_end (out_message_end),
    .out_run_last    (out_run_last)
  );

endmodule

// ===== sim/tb_unicode_escape_to_utf8.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the unicode escape to utf-8 converter
// holds its own scoreboard class; depends on ue2u_pkg and unicode_escape_to_utf8
module tb_unicode_escape_to_utf8;
  import ue2u_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 205;
  localparam int DRAIN_CYCLES = 12;

  // one result request as the block should present it
  typedef struct packed {
    logic [7:0] data;
    logic       data_ok;
    logic       msg_end;
    logic       run_end;
  } utf8_item_t;

  // tracks the escape parser and keeps the utf-8 bytes still owed by the block
  class utf8_scoreboard;
    parse_mode_t mode;
    logic [2:0]  n_taken;
    logic [15:0] acc;
    logic [7:0]  taken [4];
    bit          hex_ok;
    logic [7:0]  run_bytes [$];
    utf8_item_t  expected_q [$];
    int          errors;

    function new();
      clear_escape();
      errors = 0;
    endfunction

    function void clear_escape();
      mode    = MODE_IDLE;
      n_taken = '0;
      acc     = '0;
      hex_ok  = 1'b1;
    endfunction

    static function int digit_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      return -1;
    endfunction

    function void close_escape();
      logic [15:0] cp;
      cp = acc;
      if (hex_ok) begin
        if (cp < 16'h0080) begin
          if (cp != 16'h0000) run_bytes.push_back(cp[7:0]);
        end else if (cp < 16'h0800) begin
          run_bytes.push_back({3'b110, cp[10:6]});
          run_bytes.push_back({2'b10, cp[5:0]});
        end else begin
          run_bytes.push_back({4'b1110, cp[15:12]});
          run_bytes.push_back({2'b10, cp[11:6]});
          run_bytes.push_back({2'b10, cp[5:0]});
        end
      end else begin
        run_bytes.push_back(CH_BSLASH);
        run_bytes.push_back(CH_U);
        for (int k = 0; k < n_taken; k++) run_bytes.push_back(taken[k]);
      end
      clear_escape();
    endfunction

    function void note_input(logic [7:0] b, logic last);
      int d;
      int n;
      run_bytes = {};
      case (mode)
        MODE_BSLASH: begin
          if (b != CH_U || last) begin
            run_bytes.push_back(CH_BSLASH);
            run_bytes.push_back(b);
            clear_escape();
          end else begin
            clear_escape();
            mode = MODE_DIGITS;
          end
        end
        MODE_DIGITS: begin
          taken[n_taken[1:0]] = b;
          d = digit_of(b);
          if (d < 0) hex_ok = 1'b0;
          else acc = {acc[11:0], d[3:0]};
          n_taken = n_taken + 3'd1;
          if (n_taken >= ESCAPE_DIGITS_DEF || last) close_escape();
        end
        default: begin
          if (b != CH_BSLASH || last) begin
            run_bytes.push_back(b);
            clear_escape();
          end else begin
            clear_escape();
            mode = MODE_BSLASH;
          end
        end
      endcase
      n = run_bytes.size();
      if (n == 0) begin
        if (last) expected_q.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
      end else begin
        foreach (run_bytes[k])
          expected_q.push_back('{run_bytes[k], 1'b1, (k == n - 1) && last, k == n - 1});
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [7:0] data, logic data_ok, logic msg_end, logic run_end);
      utf8_item_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result byte=%h valid=%b end=%b run_last=%b",
                         data, data_ok, msg_end, run_end));
      end else begin
        want = expected_q.pop_front();
        if (want.data !== data || want.data_ok !== data_ok ||
            want.msg_end !== msg_end || want.run_end !== run_end)
          report($sformatf("got byte=%h valid=%b end=%b run_last=%b, want %h %b %b %b",
                           data, data_ok, msg_end, run_end,
                           want.data, want.data_ok, want.msg_end, want.run_end));
      end
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_message_last;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_message_end;
  logic       out_run_last;

  utf8_scoreboard sb = new();
  int  cycle_count = 0;
  int  sent_count  = 0;
  // while set, the matching side starts no new idle gaps
  bit  send_free   = 1'b0;
  bit  recv_free   = 1'b0;

  unicode_escape_to_utf8 DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_message_last (in_message_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_message_end (out_message_end),
    .out_run_last    (out_run_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a correct run finishes far below this
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // random idle length: mostly none or short, now and then long
  function automatic int gap_length(bit free);
    int r;
    if (free) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side: stall is set at the falling edge so it is stable at the rising edge
  initial begin
    int stall_left;
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 79) == 0) recv_free = ~recv_free;
      if (stall_left == 0 && $urandom_range(0, 2) == 0) stall_left = gap_length(recv_free);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // results are taken at the rising edge where valid is high and stall is low
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_byte, out_byte_valid, out_message_end, out_run_last);
  end

  // one input request; entered and left just after a falling edge
  task automatic send_byte(logic [7:0] b, bit last);
    int idle;
    idle = gap_length(send_free);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_byte         <= b;
    in_message_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(b, last);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_text(string s, bit close_msg);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], close_msg && i == s.len() - 1);
  endtask

  task automatic send_token(logic [7:0] tok [$], bit close_msg);
    int cut;
    // message end can land in the middle of an escape
    if (close_msg && tok.size() > 1 && $urandom_range(0, 1) == 1) begin
      cut = $urandom_range(1, tok.size() - 1);
      tok = tok[0:cut-1];
    end
    foreach (tok[i]) send_byte(tok[i], close_msg && i == tok.size() - 1);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'("0") + 8'(n);
    return ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: return CH_BSLASH;
      1: return 8'h22;
      default: begin
        c = 8'($urandom_range(0, 255));
        while (utf8_scoreboard::digit_of(c) >= 0) c = 8'($urandom_range(0, 255));
        return c;
      end
    endcase
  endfunction

  // code point picked so that every utf-8 length and the empty case show up
  function automatic logic [15:0] pick_code_point();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'($urandom_range(1, 16'h7F));
      2: return 16'($urandom_range(16'h80, 16'h7FF));
      3: return 16'($urandom_range(16'hD800, 16'hDFFF));
      4: return 16'($urandom_range(0, 16'hFFFF));
      default: begin
        case ($urandom_range(0, 4))
          0: return 16'h007F;
          1: return 16'h0080;
          2: return 16'h07FF;
          3: return 16'h0800;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  initial begin
    logic [7:0]  tok [$];
    logic [15:0] cp;
    int          r;
    int          target;
    bit          close_msg;
    bit          msg_open;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_byte         = 8'h00;
    in_message_last = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // byte extremes pass straight through, the second one ends a message
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    // lone backslash at message end
    send_text("\\", 1'b1);
    // backslash pair with a plain letter
    send_text("\\n", 1'b0);
    // backslash-u right at message end comes back raw
    send_text("\\u", 1'b1);
    // two and three byte encodings, mixed-case digits
    send_text("\\u00e9", 1'b0);
    send_text("\\uFfFf", 1'b0);
    // short escape decoding to nothing at message end gives a bare end marker
    send_text("\\u0", 1'b1);
    // short escape holding a non-hex digit replays raw
    send_text("\\u1g", 1'b1);

    // random part: random bytes, escapes with random content, some noise
    target   = sent_count + RANDOM_ITEMS;
    msg_open = 1'b0;
    while (sent_count < target) begin
      if ($urandom_range(0, 11) == 0) send_free = ~send_free;
      tok = {};
      r = $urandom_range(0, 99);
      if (r < 40) begin
        tok.push_back(8'($urandom_range(0, 255)));
      end else if (r < 82) begin
        cp = pick_code_point();
        tok = {CH_BSLASH, CH_U, hex_char(cp[15:12]), hex_char(cp[11:8]),
               hex_char(cp[7:4]), hex_char(cp[3:0])};
        // broken escape: one digit swapped for a non-hex byte
        if (r >= 70) tok[$urandom_range(2, 5)] = non_hex_char();
      end else if (r < 92) begin
        tok = {CH_BSLASH, 8'($urandom_range(0, 255))};
      end else begin
        case ($urandom_range(0, 2))
          0: tok.push_back(CH_BSLASH);
          1: tok.push_back(CH_U);
          default: tok.push_back(8'h22);
        endcase
      end
      close_msg = ($urandom_range(0, 5) == 0);
      send_token(tok, close_msg);
      msg_open = !close_msg;
    end
    // close whatever message is still open so its escape gets flushed
    if (msg_open) send_byte(8'h2E, 1'b1);
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
